/* sv/srbs_pkg.sv */
// Shared types and constants for the sparse region byte store.
// No dependencies; imported by srbs_table and sparse_region_byte_store_top.
`default_nettype none

package srbs_pkg;

    localparam int BYTE_W    = 8;
    localparam int BYTES_MAX = 8;
    localparam int SLOT_W    = 3;
    localparam int NBYTES_W  = 4;
    localparam int SPACE_W   = 3;
    localparam int ADDR_W    = 64;
    localparam int DATA_W    = 64;
    localparam int WIDTH_W   = 7;

    localparam logic [WIDTH_W-1:0] WIDTH_MAX = 7'd64;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_NO_MEM = 1'b1;

    // Lookup key of one byte entry
    typedef struct packed {
        logic [SPACE_W-1:0] space;
        logic [ADDR_W-1:0]  addr;
    } tag_t;

    // Write enables of the table
    typedef struct packed {
        logic tag;
        logic value;
    } tbl_wen_t;

endpackage

`default_nettype wire

/* sv/srbs_table.sv */
// Entry storage of the byte store: tag memory and value memory.
// Depends on srbs_pkg; one write port, one registered read port.
`default_nettype none

module srbs_table
    import srbs_pkg::*;
#(
    parameter int ENTRIES = 256,
    parameter int IDX_W   = $clog2(ENTRIES)
)
(
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  rd_idx,
    output      tag_t              rd_tag,
    output      logic [BYTE_W-1:0] rd_value,
    input  wire tbl_wen_t          wen,
    input  wire logic [IDX_W-1:0]  wr_idx,
    input  wire tag_t              wr_tag,
    input  wire logic [BYTE_W-1:0] wr_value
);

    tag_t              tag_mem   [ENTRIES];
    logic [BYTE_W-1:0] value_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wen.tag)
        begin
            tag_mem[wr_idx] <= wr_tag;
        end
        if (wen.value)
        begin
            value_mem[wr_idx] <= wr_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_tag   <= tag_mem[rd_idx];
            rd_value <= value_mem[rd_idx];
        end
    end

endmodule

`default_nettype wire

/* sv/sparse_region_byte_store_top.sv */
// Sparse region byte store: one item at a time, eight byte slots per item.
// Each active byte scans the table entries in allocation order through the single
// read port (an S_SLOT read, then an S_CMP compare per entry) and allocates on a miss.
// in_ready rises in the same cycle that the result shows; an item waits in S_FIN
// while an earlier result waits unread.
// Reset empties the table at once (fill count cleared) and drops any pending result.
`default_nettype none

module sparse_region_byte_store_top
    import srbs_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic               req_type,
    input  wire logic [SPACE_W-1:0] space_id,
    input  wire logic [ADDR_W-1:0]  byte_address,
    input  wire logic [WIDTH_W-1:0] bit_width,
    input  wire logic [DATA_W-1:0]  write_data,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic [DATA_W-1:0]  read_data,
    output      logic               status
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SLOT = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                stop_reg, stop_next;
    logic                out_valid_reg, out_valid_next;

    // Item payload held while the item is at work
    logic                is_write_reg, is_write_next;
    logic [SPACE_W-1:0]  space_reg, space_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [NBYTES_W-1:0] nbytes_reg, nbytes_next;
    logic [DATA_W-1:0]   data_reg, data_next;
    logic                status_reg, status_next;
    logic [DATA_W-1:0]   rdata_out_reg, rdata_out_next;
    logic                status_out_reg, status_out_next;

    logic [WIDTH_W-1:0]  width_clamp;
    logic [WIDTH_W:0]    width_round;
    logic                slot_active;
    logic                advance;
    logic [BYTE_W-1:0]   adv_byte;
    logic                out_free;
    tag_t                key;

    // Table ports
    logic                tbl_rd_en;
    tag_t                tbl_rd_tag;
    logic [BYTE_W-1:0]   tbl_rd_value;
    tbl_wen_t            tbl_wen;
    logic [IDX_W-1:0]    tbl_wr_idx;
    logic [BYTE_W-1:0]   tbl_wr_value;

    srbs_table #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .clk      (clk),
        .rd_en    (tbl_rd_en),
        .rd_idx   (idx_reg[IDX_W-1:0]),
        .rd_tag   (tbl_rd_tag),
        .rd_value (tbl_rd_value),
        .wen      (tbl_wen),
        .wr_idx   (tbl_wr_idx),
        .wr_tag   (key),
        .wr_value (tbl_wr_value)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign read_data = rdata_out_reg;
    assign status    = status_out_reg;

    // Clamp the width to 64 and round up to whole bytes
    assign width_clamp = (bit_width > WIDTH_MAX) ? WIDTH_MAX : bit_width;
    assign width_round = {1'b0, width_clamp} + (WIDTH_W+1)'(BYTE_W - 1);

    assign key.space   = space_reg;
    assign key.addr    = addr_reg;
    assign slot_active = ({1'b0, slot_reg} < nbytes_reg) && !stop_reg;
    assign out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        stop_next       = stop_reg;
        out_valid_next  = out_valid_reg;
        is_write_next   = is_write_reg;
        space_next      = space_reg;
        addr_next       = addr_reg;
        nbytes_next     = nbytes_reg;
        data_next       = data_reg;
        status_next     = status_reg;
        rdata_out_next  = rdata_out_reg;
        status_out_next = status_out_reg;
        advance         = 1'b0;
        adv_byte        = '0;
        tbl_rd_en       = 1'b0;
        tbl_wen         = '0;
        tbl_wr_idx      = count_reg[IDX_W-1:0];
        tbl_wr_value    = is_write_reg ? data_reg[BYTE_W-1:0] : '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    is_write_next = (req_type == REQ_WRITE);
                    space_next    = space_id;
                    addr_next     = byte_address;
                    nbytes_next   = width_round[WIDTH_W-1:3];
                    // Writes rotate their data; reads build the value from zero
                    data_next     = (req_type == REQ_WRITE) ? write_data : '0;
                    status_next   = STATUS_OK;
                    stop_next     = 1'b0;
                    slot_next     = '0;
                    idx_next      = '0;
                    state_next    = S_SLOT;
                end
            end
            S_SLOT:
            begin
                if (!slot_active)
                begin
                    // Pad slot, or any slot after a stop: rotate write data or shift in a zero byte
                    advance = 1'b1;
                end
                else if (idx_reg == count_reg)
                begin
                    // Miss: allocate the next entry, or stop when full
                    if (count_reg == CNT_FULL)
                    begin
                        status_next = STATUS_NO_MEM;
                        stop_next   = 1'b1;
                    end
                    else
                    begin
                        tbl_wen.tag   = 1'b1;
                        tbl_wen.value = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                    advance = 1'b1;
                end
                else
                begin
                    tbl_rd_en  = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (tbl_rd_tag == key)
                begin
                    // Hit: update the byte on a write, take it on a read
                    tbl_wr_idx    = idx_reg[IDX_W-1:0];
                    tbl_wen.value = is_write_reg;
                    adv_byte      = tbl_rd_value;
                    advance       = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
                state_next = S_SLOT;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    status_out_next = status_reg;
                    rdata_out_next  = (!is_write_reg && status_reg == STATUS_NO_MEM) ?
                                      '0 : data_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (advance)
        begin
            data_next  = {(is_write_reg ? data_reg[BYTE_W-1:0] : adv_byte),
                          data_reg[DATA_W-1:BYTE_W]};
            addr_next  = addr_reg + 1'b1;
            idx_next   = '0;
            slot_next  = slot_reg + 1'b1;
            state_next = (slot_reg == SLOT_W'(BYTES_MAX - 1)) ? S_FIN : S_SLOT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            idx_reg       <= '0;
            count_reg     <= '0;
            stop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            stop_reg      <= stop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_write_reg   <= is_write_next;
        space_reg      <= space_next;
        addr_reg       <= addr_next;
        nbytes_reg     <= nbytes_next;
        data_reg       <= data_next;
        status_reg     <= status_next;
        rdata_out_reg  <= rdata_out_next;
        status_out_reg <= status_out_next;
    end

endmodule

`default_nettype wire
